[rtl/pss_pkg.sv]
// ----------------------------------------------------------------------------
// pss_pkg
// shared constants and types for the population statistics core
// ----------------------------------------------------------------------------
package pss_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 24;
   localparam int COUNT_OUT_W = 11;
   localparam int ROOT_W      = 24;
   localparam int SQRT_REM_W  = ROOT_W + 2;

   // feasible limit after reset: everything is feasible
   localparam logic [SAMPLE_W-1:0] LIMIT_RESET = '1;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL_N,
      ST_MUL_S,
      ST_DIV_VAR,
      ST_SQRT,
      ST_DONE
   } back_state_type;

   // status of the hand-over queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/pss_front.sv]
// ----------------------------------------------------------------------------
// pss_front
// per-sample classification and running min, max, sum and sum of squares
// ----------------------------------------------------------------------------
module pss_front #(
   parameter int  MAX_SAMPLES = 1024,
   localparam int CW          = $clog2(MAX_SAMPLES + 1),
   localparam int SW          = pss_pkg::SAMPLE_W + CW,
   localparam int QW          = 2 * pss_pkg::SAMPLE_W + CW
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [pss_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_last_sample,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pss_pkg::SAMPLE_W-1:0]  csr_feasible_limit,
   // population summary towards the queue
   input  pss_pkg::queue_status_type     q_status,
   output logic                          q_push,
   output logic [CW-1:0]                 job_n,
   output logic [CW-1:0]                 job_bad,
   output logic [pss_pkg::SAMPLE_W-1:0]  job_min,
   output logic [pss_pkg::SAMPLE_W-1:0]  job_max,
   output logic [SW-1:0]                 job_sum,
   output logic [QW-1:0]                 job_sumsq
);
   import pss_pkg::*;

   logic [SAMPLE_W-1:0]   limit_ff;
   logic [CW-1:0]         good_ff, good_in;
   logic [CW-1:0]         bad_ff, bad_in;
   logic [SAMPLE_W-1:0]   min_ff, min_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [QW-1:0]         sumsq_ff, sumsq_in;
   logic [2*SAMPLE_W-1:0] square;
   logic                  accept;
   logic                  feasible;
   logic                  take_sum;
   logic                  take_bad;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;
   assign feasible  = req_sample <= limit_ff;
   assign take_sum  = feasible && (good_ff != CW'(MAX_SAMPLES));
   assign take_bad  = !feasible && (bad_ff != CW'(MAX_SAMPLES));
   assign square    = req_sample * req_sample;

   always_comb begin
      min_in   = (feasible && (req_sample < min_ff)) ? req_sample : min_ff;
      max_in   = (feasible && (req_sample > max_ff)) ? req_sample : max_ff;
      good_in  = take_sum ? good_ff + CW'(1) : good_ff;
      bad_in   = take_bad ? bad_ff + CW'(1) : bad_ff;
      sum_in   = take_sum ? sum_ff + SW'(req_sample) : sum_ff;
      sumsq_in = take_sum ? sumsq_ff + QW'(square) : sumsq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_feasible_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_sample)) begin
         good_ff  <= '0;
         bad_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (accept) begin
         good_ff  <= good_in;
         bad_ff   <= bad_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
      end
   end

   // summary includes the last sample itself
   assign q_push    = accept && req_last_sample;
   assign job_n     = good_in;
   assign job_bad   = bad_in;
   assign job_min   = (good_in == '0) ? '0 : min_in;
   assign job_max   = max_in;
   assign job_sum   = sum_in;
   assign job_sumsq = sumsq_in;

endmodule

[rtl/pss_queue.sv]
// ----------------------------------------------------------------------------
// pss_queue
// two-entry queue carrying population summaries from front to back
// ----------------------------------------------------------------------------
module pss_queue #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output pss_pkg::queue_status_type status
);
   import pss_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    count_ff, count_in;

   assign status.full  = count_ff == NW'(DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("summary written into a full queue");

endmodule

[rtl/pss_back.sv]
// ----------------------------------------------------------------------------
// pss_back
// per-population mean and deviation: serial multiply, divide and square root
// ----------------------------------------------------------------------------
module pss_back #(
   parameter int  MAX_SAMPLES = 1024,
   localparam int CW          = $clog2(MAX_SAMPLES + 1),
   localparam int SW          = pss_pkg::SAMPLE_W + CW,
   localparam int QW          = 2 * pss_pkg::SAMPLE_W + CW,
   localparam int DW          = 2 * pss_pkg::SAMPLE_W + 2 * CW,
   localparam int BW          = 2 * CW
) (
   input  logic                            clock,
   input  logic                            reset,
   // population summary from the queue
   input  pss_pkg::queue_status_type       q_status,
   output logic                            q_pop,
   input  logic [CW-1:0]                   job_n,
   input  logic [CW-1:0]                   job_bad,
   input  logic [pss_pkg::SAMPLE_W-1:0]    job_min,
   input  logic [pss_pkg::SAMPLE_W-1:0]    job_max,
   input  logic [SW-1:0]                   job_sum,
   input  logic [QW-1:0]                   job_sumsq,
   // result channel
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_feasible_count,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_rejected_count,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_minimum,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_maximum,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_mean,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_std_dev
);
   import pss_pkg::*;

   localparam int IW = $clog2(DW + 1);

   back_state_type          state_ff, state_in;

   logic [CW-1:0]           n_ff;
   logic [CW-1:0]           bad_ff;
   logic [SAMPLE_W-1:0]     min_ff;
   logic [SAMPLE_W-1:0]     max_ff;
   logic [SW-1:0]           sum_ff;
   logic [QW-1:0]           sumsq_ff;
   logic [BW-1:0]           b_ff;
   logic [SAMPLE_W-1:0]     mean_ff;
   logic [ROOT_W-1:0]       std_ff;

   // shared datapath registers
   logic [IW-1:0]           cnt_ff;
   logic [DW-1:0]           quo_ff, quo_in;
   logic [BW-1:0]           rem_ff, rem_in;
   logic [BW-1:0]           div_ff;
   logic [DW-1:0]           acc_ff;
   logic [DW-1:0]           mcand_ff;
   logic [SW-1:0]           mplier_ff;
   logic [SQRT_REM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;

   logic                    out_valid_ff;
   logic                    out_free;
   logic                    out_load;
   logic                    last_step;

   logic [BW:0]             rem_shift;
   logic                    div_ge;
   logic [DW-1:0]           mc_term;
   logic [SQRT_REM_W-1:0]   srem_shift;
   logic [SQRT_REM_W-1:0]   trial;
   logic                    sqrt_ge;
   logic                    var_cap;

   assign last_step = cnt_ff == IW'(1);
   assign out_free  = !out_valid_ff || rsp_pop;

   // restoring divide step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DW-1]};
      div_ge    = rem_shift >= {1'b0, div_ff};
      rem_in    = div_ge ? BW'(rem_shift - {1'b0, div_ff}) : BW'(rem_shift);
      quo_in    = {quo_ff[DW-2:0], div_ge};
      var_cap   = quo_in[DW-1:2*ROOT_W] != '0;
   end

   // shift-add multiply step
   assign mc_term = mplier_ff[0] ? mcand_ff : '0;

   // square root step, two radicand bits a cycle
   always_comb begin
      srem_shift = {srem_ff[SQRT_REM_W-3:0], acc_ff[2*ROOT_W-1 -: 2]};
      trial      = {root_ff, 2'b01};
      sqrt_ge    = srem_shift >= trial;
      srem_in    = sqrt_ge ? srem_shift - trial : srem_shift;
      root_in    = {root_ff[ROOT_W-2:0], sqrt_ge};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = (job_n == '0) ? ST_DONE : ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (last_step) begin
               state_in = (n_ff < CW'(2)) ? ST_DONE : ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            if (mplier_ff == '0) begin
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: begin
            if (mplier_ff == '0) begin
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (last_step) begin
               state_in = var_cap ? ST_DONE : ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && !q_status.empty;
      out_load = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               n_ff     <= job_n;
               bad_ff   <= job_bad;
               min_ff   <= job_min;
               max_ff   <= job_max;
               sum_ff   <= job_sum;
               sumsq_ff <= job_sumsq;
               b_ff     <= BW'(job_n) * BW'(job_n - CW'(1));
               quo_ff   <= {job_sum, {(DW-SW){1'b0}}};
               rem_ff   <= '0;
               div_ff   <= BW'(job_n);
               cnt_ff   <= IW'(SW);
               mean_ff  <= '0;
               std_ff   <= '0;
            end
         end
         ST_DIV_MEAN: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - IW'(1);
            if (last_step) begin
               mean_ff   <= quo_in[SAMPLE_W-1:0];
               acc_ff    <= '0;
               mcand_ff  <= DW'(sumsq_ff);
               mplier_ff <= SW'(n_ff);
            end
         end
         ST_MUL_N: begin
            if (mplier_ff == '0) begin
               mcand_ff  <= DW'(sum_ff);
               mplier_ff <= sum_ff;
            end else begin
               acc_ff    <= acc_ff + mc_term;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
            end
         end
         ST_MUL_S: begin
            if (mplier_ff == '0) begin
               quo_ff <= acc_ff;
               rem_ff <= '0;
               div_ff <= b_ff;
               cnt_ff <= IW'(DW);
            end else begin
               acc_ff    <= acc_ff - mc_term;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
            end
         end
         ST_DIV_VAR: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            if (last_step && !var_cap) begin
               acc_ff  <= DW'(quo_in[2*ROOT_W-1:0]);
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff  <= IW'(ROOT_W);
            end else begin
               cnt_ff <= cnt_ff - IW'(1);
               if (last_step) begin
                  std_ff <= '1;
               end
            end
         end
         ST_SQRT: begin
            srem_ff <= srem_in;
            root_ff <= root_in;
            acc_ff  <= acc_ff << 2;
            cnt_ff  <= cnt_ff - IW'(1);
            if (last_step) begin
               std_ff <= root_in;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_feasible_count <= COUNT_OUT_W'(n_ff);
         rsp_rejected_count <= COUNT_OUT_W'(bad_ff);
         rsp_minimum        <= min_ff;
         rsp_maximum        <= max_ff;
         rsp_mean           <= mean_ff;
         rsp_std_dev        <= std_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;

   a_div_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_VAR) |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   a_short_population_no_std : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && n_ff < CW'(2)) |-> std_ff == '0)
      else $error("deviation nonzero for fewer than two feasible samples");

endmodule

[rtl/population_stats_min_max_mean_std_core.sv]
// the last sample enters the summary queue at its own edge; the back end then runs the
//   mean divide, the two serial multiplies, the variance divide and the root, as far as
//   the population needs them, and then loads the result and hands it over
// throughput: one sample a cycle until both queue entries wait, then samples stall;
//   one population result per back end run
// reset: synchronous, clears statistics, queue and result slot; limit goes to all ones
// ----------------------------------------------------------------------------
// population_stats_min_max_mean_std_core
// streaming feasible/rejected counts, min, max, mean and sample deviation
// ----------------------------------------------------------------------------
module population_stats_min_max_mean_std_core #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample transactions
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [pss_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_last_sample,
   // result transactions
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_feasible_count,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_rejected_count,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_minimum,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_maximum,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_mean,
   output logic [pss_pkg::SAMPLE_W-1:0]    rsp_std_dev,
   // feasible limit register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pss_pkg::SAMPLE_W-1:0]    csr_feasible_limit
);
   import pss_pkg::*;

   // count, sum and sum-of-squares widths follow the population size
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = SAMPLE_W + CW;
   localparam int QW = 2 * SAMPLE_W + CW;
   localparam int JW = 2 * CW + 2 * SAMPLE_W + SW + QW;

   queue_status_type    q_status;
   logic                q_push;
   logic                q_pop;
   logic [JW-1:0]       q_wr_data;
   logic [JW-1:0]       q_rd_data;

   // summary fields on the front side
   logic [CW-1:0]       f_n;
   logic [CW-1:0]       f_bad;
   logic [SAMPLE_W-1:0] f_min;
   logic [SAMPLE_W-1:0] f_max;
   logic [SW-1:0]       f_sum;
   logic [QW-1:0]       f_sumsq;

   // summary fields on the back side
   logic [CW-1:0]       b_n;
   logic [CW-1:0]       b_bad;
   logic [SAMPLE_W-1:0] b_min;
   logic [SAMPLE_W-1:0] b_max;
   logic [SW-1:0]       b_sum;
   logic [QW-1:0]       b_sumsq;

   // front: classifies each sample and keeps the running statistics,
   // hands a summary over on the last sample of a population
   pss_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_feasible_limit (csr_feasible_limit),
      .q_status           (q_status),
      .q_push             (q_push),
      .job_n              (f_n),
      .job_bad            (f_bad),
      .job_min            (f_min),
      .job_max            (f_max),
      .job_sum            (f_sum),
      .job_sumsq          (f_sumsq)
   );

   // short queue so the front keeps taking samples while the back works
   assign q_wr_data = {f_n, f_bad, f_min, f_max, f_sum, f_sumsq};

   pss_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .status    (q_status)
   );

   assign {b_n, b_bad, b_min, b_max, b_sum, b_sumsq} = q_rd_data;

   // back: mean by division, variance numerator by shift-add multiply,
   // then divide by n*(n-1) and take the square root; owns the result slot
   pss_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_pop              (q_pop),
      .job_n              (b_n),
      .job_bad            (b_bad),
      .job_min            (b_min),
      .job_max            (b_max),
      .job_sum            (b_sum),
      .job_sumsq          (b_sumsq),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_feasible_count (rsp_feasible_count),
      .rsp_rejected_count (rsp_rejected_count),
      .rsp_minimum        (rsp_minimum),
      .rsp_maximum        (rsp_maximum),
      .rsp_mean           (rsp_mean),
      .rsp_std_dev        (rsp_std_dev)
   );

   // the mean always lies between the extremes (all zero for an empty population)
   a_mean_within_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_minimum <= rsp_mean) && (rsp_mean <= rsp_maximum))
      else $error("mean outside minimum and maximum");

endmodule

[bench/population_stats_checker.sv]
// ----------------------------------------------------------------------------
// population_stats_checker
// watches the sample, limit and summary channels of the population statistics
// core, predicts each population summary and compares it field by field
// ----------------------------------------------------------------------------
module population_stats_checker #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic                            req_full,
   input  logic [pss_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_last_sample,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [pss_pkg::COUNT_OUT_W-1:0] rsp_feasible_count,
   input  logic [pss_pkg::COUNT_OUT_W-1:0] rsp_rejected_count,
   input  logic [pss_pkg::SAMPLE_W-1:0]    rsp_minimum,
   input  logic [pss_pkg::SAMPLE_W-1:0]    rsp_maximum,
   input  logic [pss_pkg::SAMPLE_W-1:0]    rsp_mean,
   input  logic [pss_pkg::SAMPLE_W-1:0]    rsp_std_dev,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pss_pkg::SAMPLE_W-1:0]    csr_feasible_limit,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   typedef struct {
      logic [COUNT_OUT_W-1:0] feasible_count;
      logic [COUNT_OUT_W-1:0] rejected_count;
      logic [SAMPLE_W-1:0]    minimum;
      logic [SAMPLE_W-1:0]    maximum;
      logic [SAMPLE_W-1:0]    mean;
      logic [SAMPLE_W-1:0]    std_dev;
   } population_summary_type;

   population_summary_type awaited_summaries[$];

   logic [SAMPLE_W-1:0]    limit;
   logic [COUNT_OUT_W-1:0] feasible_seen;
   logic [COUNT_OUT_W-1:0] rejected_seen;
   logic [SAMPLE_W-1:0]    lowest;
   logic [SAMPLE_W-1:0]    highest;
   logic [33:0]            sample_sum;
   logic [57:0]            square_sum;
   int                     mismatches = 0;

   assign fail_count = mismatches;

   task automatic clear_population();
      feasible_seen = '0;
      rejected_seen = '0;
      lowest        = '1;
      highest       = '0;
      sample_sum    = '0;
      square_sum    = '0;
   endtask

   // largest r with r*r*n*(n-1) <= n*sum_sq - sum*sum, found bit by bit
   function automatic logic [SAMPLE_W-1:0] deviation_of(logic [COUNT_OUT_W-1:0] n,
                                                       logic [33:0] total,
                                                       logic [57:0] squares);
      logic [127:0]        scaled_sq;
      logic [127:0]        total_sq;
      logic [127:0]        spread;
      logic [127:0]        pairs;
      logic [SAMPLE_W-1:0] root;
      logic [SAMPLE_W-1:0] trial;
      if (n < 2) return '0;
      scaled_sq = 128'(n) * 128'(squares);
      total_sq  = 128'(total) * 128'(total);
      if (total_sq > scaled_sq) return '0;
      spread = scaled_sq - total_sq;
      pairs  = 128'(n) * 128'(n - 1);
      root   = '0;
      for (int b = SAMPLE_W - 1; b >= 0; b--) begin
         trial = root | (SAMPLE_W'(1) << b);
         if (128'(trial) * 128'(trial) * pairs <= spread) root = trial;
      end
      return root;
   endfunction

   task automatic take_sample(input logic [SAMPLE_W-1:0] x, input logic closes);
      population_summary_type summary;
      if (x <= limit) begin
         if (x < lowest) lowest = x;
         if (x > highest) highest = x;
         if (feasible_seen < MAX_SAMPLES) begin
            feasible_seen++;
            sample_sum += x;
            square_sum += 58'(x) * 58'(x);
         end
      end else if (rejected_seen < MAX_SAMPLES) begin
         rejected_seen++;
      end
      if (closes) begin
         summary.feasible_count = feasible_seen;
         summary.rejected_count = rejected_seen;
         if (feasible_seen == 0) begin
            summary.minimum = '0;
            summary.maximum = '0;
            summary.mean    = '0;
            summary.std_dev = '0;
         end else begin
            summary.minimum = lowest;
            summary.maximum = highest;
            summary.mean    = SAMPLE_W'(sample_sum / feasible_seen);
            summary.std_dev = deviation_of(feasible_seen, sample_sum, square_sum);
         end
         awaited_summaries = {awaited_summaries, summary};
         clear_population();
      end
   endtask

   task automatic compare_field(input string field, input logic [SAMPLE_W-1:0] want,
                                input logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      population_summary_type oldest;
      if (reset) begin
         limit = LIMIT_RESET;
         clear_population();
         awaited_summaries.delete();
      end else begin
         // result side first, so a summary can never match its own sample
         if (rsp_pop && !rsp_empty) begin
            if (awaited_summaries.size() == 0) begin
               $error("summary transaction with none awaited");
               mismatches++;
            end else begin
               oldest = awaited_summaries.pop_front();
               compare_field("feasible_count", oldest.feasible_count, rsp_feasible_count);
               compare_field("rejected_count", oldest.rejected_count, rsp_rejected_count);
               compare_field("minimum", oldest.minimum, rsp_minimum);
               compare_field("maximum", oldest.maximum, rsp_maximum);
               compare_field("mean", oldest.mean, rsp_mean);
               compare_field("std_dev", oldest.std_dev, rsp_std_dev);
            end
         end
         // a sample at the same edge as a limit write still sees the old limit
         if (req_push && !req_full) take_sample(req_sample, req_last_sample);
         if (csr_valid && csr_ready) limit = csr_feasible_limit;
      end
      pending_count <= awaited_summaries.size();
   end

endmodule

[bench/tb_population_stats_min_max_mean_std_core.sv]
// ----------------------------------------------------------------------------
// tb_population_stats_min_max_mean_std_core
// drives sample populations and feasible limit writes into the statistics
// core under varying sender gaps and receiver stalls; a checker beside the
// core predicts every summary and reports mismatches for the final verdict
// ----------------------------------------------------------------------------
module tb_population_stats_min_max_mean_std_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int MAX_SAMPLES   = 1024;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 11;
   // settle time, more than twice what the back end takes for one population
   localparam int SETTLE_CYCLES = 400;
   // long enough for the summary queue to fill and stall the samples
   localparam int HOLD_CYCLES   = 3000;
   localparam int PHASE_ITEMS   = 100;
   localparam int LONG_PAIRS    = 90;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   req_last_sample;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [COUNT_OUT_W-1:0] rsp_feasible_count;
   logic [COUNT_OUT_W-1:0] rsp_rejected_count;
   logic [SAMPLE_W-1:0]    rsp_minimum;
   logic [SAMPLE_W-1:0]    rsp_maximum;
   logic [SAMPLE_W-1:0]    rsp_mean;
   logic [SAMPLE_W-1:0]    rsp_std_dev;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [SAMPLE_W-1:0]    csr_feasible_limit;

   int failures;
   int pending_results;

   // idling odds in percent, changed per phase by the main sequence
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // bumped by the main sequence to ask the receiver for one long hold-off
   int hold_requests = 0;

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   population_stats_min_max_mean_std_core #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_feasible_count (rsp_feasible_count),
      .rsp_rejected_count (rsp_rejected_count),
      .rsp_minimum        (rsp_minimum),
      .rsp_maximum        (rsp_maximum),
      .rsp_mean           (rsp_mean),
      .rsp_std_dev        (rsp_std_dev),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_feasible_limit (csr_feasible_limit)
   );

   population_stats_checker #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_feasible_count (rsp_feasible_count),
      .rsp_rejected_count (rsp_rejected_count),
      .rsp_minimum        (rsp_minimum),
      .rsp_maximum        (rsp_maximum),
      .rsp_mean           (rsp_mean),
      .rsp_std_dev        (rsp_std_dev),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_feasible_limit (csr_feasible_limit),
      .fail_count         (failures),
      .pending_count      (pending_results)
   );

   // receiver: random stalls, plus a long hold-off counted here on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one sample transaction; push stays high if the next one follows at once
   task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input logic closes);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push        <= 1'b0;
         req_sample      <= 24'($urandom);
         req_last_sample <= 1'($urandom);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_sample      <= value;
      req_last_sample <= closes;
      do @(posedge clock); while (req_full);
   endtask

   // stop offering, then wait until every awaited summary has come out
   task automatic wait_for_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results != 0) @(posedge clock);
   endtask

   // limit writes only with the core quiet: drained and back end settled
   task automatic write_limit(input logic [SAMPLE_W-1:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_feasible_limit <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // samples biased towards the limit edge, the extremes and small values
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] limit);
      unique case ($urandom_range(5))
         0: return 24'($urandom);
         1: return 24'($urandom_range(limit));
         2: return limit + 24'($urandom_range(4)) - 24'd2;
         3: return $urandom_range(1) ? FULL_SCALE : '0;
         4: return 24'($urandom_range(255));
         default: return 24'($urandom) | 24'hF00000;
      endcase
   endfunction

   // a run of random populations, each closed by a last sample
   task automatic random_phase(input logic [SAMPLE_W-1:0] limit, input int send_pct,
                               input int recv_pct, input bit with_hold,
                               input bit with_drain);
      int sent;
      int length;
      bit drained;
      write_limit(limit);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (with_hold) hold_requests++;
      sent    = 0;
      drained = 1'b0;
      while (sent < PHASE_ITEMS) begin
         // mostly short populations so summaries are frequent, a few longer
         length = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
         for (int k = 0; k < length; k++) begin
            offer_sample(pick_sample(limit), k == length - 1);
            sent++;
         end
         if (with_drain && !drained && sent >= PHASE_ITEMS / 2) begin
            // sender pauses mid-phase until the receiver has caught up
            drained = 1'b1;
            wait_for_results();
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_push           = 1'b0;
      req_sample         = '0;
      req_last_sample    = 1'b0;
      csr_valid          = 1'b0;
      csr_feasible_limit = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed populations, limit still at its reset value of full scale
      send_idle_pct  = 17;
      recv_stall_pct = 17;
      offer_sample('0, 1'b1);                   // one sample of zero, deviation zero
      offer_sample(FULL_SCALE, 1'b1);           // one sample at full scale, on the limit
      offer_sample(FULL_SCALE, 1'b0);           // widest spread the fields allow
      offer_sample('0, 1'b0);
      offer_sample(FULL_SCALE, 1'b0);
      offer_sample('0, 1'b1);
      offer_sample(24'h123456, 1'b0);           // two equal samples
      offer_sample(24'h123456, 1'b1);
      offer_sample(24'h000001, 1'b0);           // mean and deviation truncation
      offer_sample(24'h000002, 1'b0);
      offer_sample(24'h000004, 1'b1);

      write_limit(24'h000100);
      offer_sample(24'h000101, 1'b0);           // no feasible samples at all
      offer_sample(FULL_SCALE, 1'b1);
      offer_sample(24'h000100, 1'b0);           // exactly on the limit counts as feasible
      offer_sample(24'h000101, 1'b0);
      offer_sample('0, 1'b1);

      write_limit('0);
      offer_sample(24'h000001, 1'b0);
      offer_sample('0, 1'b1);
      offer_sample(FULL_SCALE, 1'b1);

      // one long back-to-back population mixing feasible and rejected samples
      write_limit(24'h800000);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < LONG_PAIRS; i++) begin
         offer_sample(24'($urandom_range(24'h7FFF00, 24'h000100)), 1'b0);
         offer_sample(24'($urandom_range(24'hFFFFFF, 24'h800001)), 1'b0);
      end
      offer_sample('0, 1'b0);
      offer_sample(24'h800000, 1'b1);

      // random phases across the idling mixes; the first holds the receiver off
      random_phase(24'($urandom), 0, 0, 1'b1, 1'b0);
      random_phase(FULL_SCALE, 55, 0, 1'b0, 1'b1);
      random_phase(24'($urandom_range(24'h001000)), 0, 55, 1'b0, 1'b0);
      random_phase(24'($urandom), 17, 17, 1'b0, 1'b0);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
